// ----- src/project_points_mask_select_core_defines.svh -----
// ----------------------------------------------------------------------------
// Point projection mask filter: assertion macros
// Concurrent check wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef PROJECT_POINTS_MASK_SELECT_CORE_DEFINES_SVH
`define PROJECT_POINTS_MASK_SELECT_CORE_DEFINES_SVH

`ifndef SYNTH
`define PPMS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppms check failed");
`define PPMS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppms check failed");
`else
`define PPMS_ASSERT_NOW(lbl, ante, cons)
`define PPMS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/ppms_pkg.sv -----
// ----------------------------------------------------------------------------
// Point projection mask filter package
// Shared constants, codes and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppms_pkg;

   localparam int MASK_MAX_WIDTH  = 1024;
   localparam int MASK_MAX_HEIGHT = 1024;
   localparam int COORD_BITS      = 32;

   localparam int SUM_W    = COORD_BITS + 16;
   localparam int PSUM_W   = 50;
   localparam int EXT_W    = ((SUM_W > PSUM_W) ? SUM_W : PSUM_W) + 1;
   localparam int QBITS    = 16;
   localparam int DIV_W    = SUM_W + QBITS;
   localparam int UW       = $clog2(MASK_MAX_WIDTH + 1);
   localparam int HW       = $clog2(MASK_MAX_HEIGHT + 1);
   localparam int IDX_W    = UW + HW;
   localparam int MADDR_W  = 14;
   localparam int MASK_WORDS = 1 << MADDR_W;

   localparam int IN_DATA_W  = 176;
   localparam int OUT_DATA_W = 136;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic OP_MASK  = 1'b0;
   localparam logic OP_POINT = 1'b1;

   localparam logic [1:0] V_SELECTED = 2'd0;
   localparam logic [1:0] V_SHALLOW  = 2'd1;
   localparam logic [1:0] V_OUTSIDE  = 2'd2;
   localparam logic [1:0] V_MASKED   = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_ROW0_LO = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW0_HI = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW1_LO = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW1_HI = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW2_LO = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ROW2_HI = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_DEPTH = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_SIZE = 3'd7;

   localparam logic [30:0] MIN_DEPTH_RST  = 31'd6554;
   localparam logic [31:0] IMAGE_SIZE_RST = 32'd67109888;

   typedef struct packed {
      logic                     op;
      logic [MADDR_W-1:0]       maddr;
      logic [63:0]              mword;
      logic signed [31:0]       x;
      logic signed [31:0]       y;
      logic signed [31:0]       z;
   } item_type;

   typedef struct packed {
      logic             neg;
      logic             sat;
      logic [SUM_W-1:0] rem;
      logic [QBITS-1:0] quo;
   } div_type;

endpackage

// ----- src/project_points_mask_select_core.sv -----
// ----------------------------------------------------------------------------
// Point projection mask filter
// Projects Q16.16 points through a 3x4 matrix and classifies them
// against a 64-bit-word pixel mask.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: tuser = operation; tdata = mask_addr, mask_word, x, y, z.
//  A mask-write transfer stores one 64-bit word and yields no result.
//  A point transfer yields one rsp_ transfer: verdict, point, pixel u/v.
//  csr_ port writes the projection, min depth and image size registers;
//  the user must write them only while the block is idle, as the block itself leaves this unenforced.
//  There are 23 register stages between a req transfer and its result;
//  one item per cycle is sustained while the rsp_ side is ready.
//  The 16 stages of the two restoring dividers (one quotient bit each)
//  set the depth. Mask writes land in the memory stage, in item order
//  with the point lookups.
//  Every stage holds its item while the next one is full and stalled; an
//  empty stage still accepts, so a stalled rsp_ side backs up the
//  pipeline one stage at a time and nothing is lost or repeated.
//  Reset clears all valid bits and the configuration registers; the mask memory is
//  not cleared and must be written before points look it up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "project_points_mask_select_core_defines.svh"

module project_points_mask_select_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // mask_addr, mask_word, point_x, point_y, point_z, zero pad
   input  logic [ppms_pkg::IN_DATA_W-1:0]      req_tdata,
   // operation
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // verdict, out_x, out_y, out_z, pixel_u, pixel_v, zero pad
   output logic [ppms_pkg::OUT_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [ppms_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ppms_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ppms_pkg::*;

   localparam int NST   = 23;
   localparam int ST_P  = 1;
   localparam int ST_S  = 2;
   localparam int ST_D0 = 3;
   localparam int ST_R  = ST_D0 + QBITS + 1;
   localparam int ST_A  = ST_R + 1;
   localparam int ST_M  = ST_A + 1;

   localparam logic signed [EXT_W-1:0] SUM_HI = EXT_W'((65'sd1 <<< (SUM_W - 1)) - 65'sd1);
   localparam logic signed [EXT_W-1:0] SUM_LO = -SUM_HI - EXT_W'(1);

   // configuration
   logic [63:0]  proj_ff [0:5];
   logic [30:0]  min_depth_ff;
   logic [31:0]  image_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) proj_ff[i] <= '0;
         min_depth_ff  <= MIN_DEPTH_RST;
         image_size_ff <= IMAGE_SIZE_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_ROW0_LO, CSR_ROW0_HI, CSR_ROW1_LO,
            CSR_ROW1_HI, CSR_ROW2_LO, CSR_ROW2_HI: proj_ff[csr_addr] <= csr_wdata;
            CSR_MIN_DEPTH:  min_depth_ff  <= csr_wdata[30:0];
            CSR_IMAGE_SIZE: image_size_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic signed [31:0] m [0:2][0:3];
   logic [UW-1:0]      width_c;
   logic [HW-1:0]      height_c;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            m[r][c] = (c % 2 == 1) ? $signed(proj_ff[r*2 + c/2][63:32])
                                   : $signed(proj_ff[r*2 + c/2][31:0]);
         end
      end
      width_c  = (image_size_ff[15:0] > 16'(MASK_MAX_WIDTH)) ? UW'(MASK_MAX_WIDTH)
                                                            : UW'(image_size_ff[15:0]);
      height_c = (image_size_ff[31:16] > 16'(MASK_MAX_HEIGHT)) ? HW'(MASK_MAX_HEIGHT)
                                                              : HW'(image_size_ff[31:16]);
   end

   // pipeline control
   logic [NST:0]   v_ff;
   logic [NST+1:1] en;
   item_type       pay_ff [1:ST_M];
   item_type       req_item;

   assign req_item.op    = req_tuser;
   assign req_item.maddr = req_tdata[13:0];
   assign req_item.mword = req_tdata[77:14];
   assign req_item.x     = $signed(req_tdata[109:78]);
   assign req_item.y     = $signed(req_tdata[141:110]);
   assign req_item.z     = $signed(req_tdata[173:142]);

   always_comb begin
      en[NST+1] = rsp_tready;
      for (int k = NST; k >= 1; k--) en[k] = !v_ff[k] || en[k+1];
   end

   assign req_tready = en[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NST; k++) begin
            if (en[k]) begin
               if (k == 1)
                  v_ff[k] <= req_tvalid;
               else if (k == ST_M)
                  v_ff[k] <= v_ff[k-1] && (pay_ff[k-1].op == OP_POINT);
               else
                  v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) pay_ff[1] <= req_item;
      for (int k = 2; k <= ST_M; k++) begin
         if (en[k]) pay_ff[k] <= pay_ff[k-1];
      end
   end

   // stage P: products
   logic signed [63:0] prod_ff [0:2][0:2];

   always_ff @(posedge clock) begin
      if (en[ST_P]) begin
         for (int r = 0; r < 3; r++) begin
            prod_ff[r][0] <= m[r][0] * req_item.x;
            prod_ff[r][1] <= m[r][1] * req_item.y;
            prod_ff[r][2] <= m[r][2] * req_item.z;
         end
      end
   end

   // stage S: row sums
   logic signed [SUM_W-1:0] dot_ff [0:2];
   logic signed [EXT_W-1:0] dsum   [0:2];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         dsum[r] = EXT_W'($signed(prod_ff[r][0][63:16])) + EXT_W'($signed(prod_ff[r][1][63:16]))
                 + EXT_W'($signed(prod_ff[r][2][63:16])) + EXT_W'(m[r][3]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_S]) begin
         for (int r = 0; r < 3; r++) begin
            if (dsum[r] > SUM_HI)
               dot_ff[r] <= SUM_HI[SUM_W-1:0];
            else if (dsum[r] < SUM_LO)
               dot_ff[r] <= SUM_LO[SUM_W-1:0];
            else
               dot_ff[r] <= dsum[r][SUM_W-1:0];
         end
      end
   end

   // stage D0..D16: sign, overflow check and restoring division
   div_type          du_ff [0:QBITS];
   div_type          dv_ff [0:QBITS];
   div_type          du_in [1:QBITS];
   div_type          dv_in [1:QBITS];
   logic [DIV_W-1:0] dsub  [1:QBITS];
   logic [SUM_W-1:0] wd_ff [0:QBITS];
   logic             sh_ff [ST_D0:ST_M];
   logic [SUM_W-1:0] mag_a, mag_b;
   logic             shallow;

   always_comb begin
      mag_a = dot_ff[0][SUM_W-1] ? SUM_W'(-dot_ff[0]) : dot_ff[0];
      mag_b = dot_ff[1][SUM_W-1] ? SUM_W'(-dot_ff[1]) : dot_ff[1];
      shallow = (dot_ff[2] <= 0) || (dot_ff[2] < $signed(SUM_W'(min_depth_ff)));
   end

   always_comb begin
      for (int k = 1; k <= QBITS; k++) begin
         dsub[k]  = DIV_W'(wd_ff[k-1]) << (QBITS - k);
         du_in[k] = du_ff[k-1];
         dv_in[k] = dv_ff[k-1];
         if (DIV_W'(du_ff[k-1].rem) >= dsub[k]) begin
            du_in[k].rem = SUM_W'(DIV_W'(du_ff[k-1].rem) - dsub[k]);
            du_in[k].quo[QBITS-k] = 1'b1;
         end
         if (DIV_W'(dv_ff[k-1].rem) >= dsub[k]) begin
            dv_in[k].rem = SUM_W'(DIV_W'(dv_ff[k-1].rem) - dsub[k]);
            dv_in[k].quo[QBITS-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_D0]) begin
         du_ff[0].neg <= dot_ff[0][SUM_W-1];
         du_ff[0].sat <= DIV_W'(mag_a) >= {dot_ff[2], {QBITS{1'b0}}};
         du_ff[0].rem <= mag_a;
         du_ff[0].quo <= '0;
         dv_ff[0].neg <= dot_ff[1][SUM_W-1];
         dv_ff[0].sat <= DIV_W'(mag_b) >= {dot_ff[2], {QBITS{1'b0}}};
         dv_ff[0].rem <= mag_b;
         dv_ff[0].quo <= '0;
         wd_ff[0]     <= dot_ff[2];
         sh_ff[ST_D0] <= shallow;
      end
      for (int k = 1; k <= QBITS; k++) begin
         if (en[ST_D0 + k]) begin
            du_ff[k] <= du_in[k];
            dv_ff[k] <= dv_in[k];
            wd_ff[k] <= wd_ff[k-1];
         end
      end
      for (int k = ST_D0 + 1; k <= ST_M; k++) begin
         if (en[k]) sh_ff[k] <= sh_ff[k-1];
      end
   end

   // stage R: rounding, saturation, bounds
   function automatic logic signed [15:0] pix_round(div_type d, logic [SUM_W-1:0] w);
      logic [QBITS:0] q;
      logic           big;
      q   = {1'b0, d.quo} + (QBITS+1)'({d.rem, 1'b0} >= {1'b0, w});
      big = d.sat || (d.neg ? (q > (QBITS+1)'(32768)) : (q > (QBITS+1)'(32767)));
      if (big)
         return d.neg ? 16'sh8000 : 16'sh7fff;
      return d.neg ? -$signed(q[15:0]) : $signed(q[15:0]);
   endfunction

   logic signed [15:0] u_c, v_c;
   logic signed [15:0] u_ff [ST_R:NST-1];
   logic signed [15:0] v_ff2 [ST_R:NST-1];
   logic               out_ff [ST_R:ST_M];

   always_comb begin
      u_c = pix_round(du_ff[QBITS], wd_ff[QBITS]);
      v_c = pix_round(dv_ff[QBITS], wd_ff[QBITS]);
   end

   always_ff @(posedge clock) begin
      if (en[ST_R]) begin
         u_ff[ST_R]   <= sh_ff[ST_R-1] ? 16'sd0 : u_c;
         v_ff2[ST_R]  <= sh_ff[ST_R-1] ? 16'sd0 : v_c;
         out_ff[ST_R] <= u_c[15] || v_c[15] || (u_c >= $signed(16'(width_c)))
                         || (v_c >= $signed(16'(height_c)));
      end
      for (int k = ST_R + 1; k <= NST - 1; k++) begin
         if (en[k]) begin
            u_ff[k]  <= u_ff[k-1];
            v_ff2[k] <= v_ff2[k-1];
         end
      end
      for (int k = ST_R + 1; k <= ST_M; k++) begin
         if (en[k]) out_ff[k] <= out_ff[k-1];
      end
   end

   // stage A: mask address
   logic [IDX_W-1:0]   idx_c;
   logic [MADDR_W-1:0] addr_ff;
   logic [5:0]         bit_ff [ST_A:ST_M];

   assign idx_c = IDX_W'(v_ff2[ST_A-1][HW-1:0]) * IDX_W'(width_c)
                + IDX_W'(u_ff[ST_A-1][UW-1:0]);

   always_ff @(posedge clock) begin
      if (en[ST_A]) begin
         addr_ff       <= (pay_ff[ST_A-1].op == OP_POINT) ? MADDR_W'(idx_c >> 6)
                                                          : pay_ff[ST_A-1].maddr;
         bit_ff[ST_A]  <= idx_c[5:0];
      end
      if (en[ST_M]) bit_ff[ST_M] <= bit_ff[ST_A];
   end

   // stage M: mask memory, writes and reads in item order
   logic [63:0] mask_mem [0:MASK_WORDS-1];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (en[ST_M] && v_ff[ST_A] && (pay_ff[ST_A].op == OP_MASK))
         mask_mem[addr_ff] <= pay_ff[ST_A].mword;
      if (en[ST_M] && v_ff[ST_A] && (pay_ff[ST_A].op == OP_POINT))
         rd_data_ff <= mask_mem[addr_ff];
   end

   // output register
   logic [1:0]         verdict_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic signed [15:0] ou_ff, ov_ff;

   always_ff @(posedge clock) begin
      if (en[NST]) begin
         if (sh_ff[ST_M])
            verdict_ff <= V_SHALLOW;
         else if (out_ff[ST_M])
            verdict_ff <= V_OUTSIDE;
         else if (rd_data_ff[bit_ff[ST_M]])
            verdict_ff <= V_SELECTED;
         else
            verdict_ff <= V_MASKED;
         ox_ff <= pay_ff[ST_M].x;
         oy_ff <= pay_ff[ST_M].y;
         oz_ff <= pay_ff[ST_M].z;
         ou_ff <= u_ff[ST_M];
         ov_ff <= v_ff2[ST_M];
      end
   end

   assign rsp_tvalid = v_ff[NST];
   assign rsp_tdata  = {6'd0, ov_ff, ou_ff, oz_ff, oy_ff, ox_ff, verdict_ff};

   `PPMS_ASSERT_NOW(a_no_write_result, v_ff[ST_M], pay_ff[ST_M].op == OP_POINT)
   `PPMS_ASSERT_NOW(a_shallow_zero_pixel, rsp_tvalid && (verdict_ff == V_SHALLOW),
                    (ou_ff == 16'sd0) && (ov_ff == 16'sd0))
   `PPMS_ASSERT_NOW(a_ready_when_empty, !v_ff[1], req_tready)
   `PPMS_ASSERT_NOW(a_div_rem_bound, v_ff[ST_R-1] && !sh_ff[ST_R-1] && !du_ff[QBITS].sat,
                    du_ff[QBITS].rem < wd_ff[QBITS])

endmodule
